### sv/sgfr_pkg.sv
package sgfr_pkg;

    // Receive buffer size and the widths that follow from it.
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);

    // Fixed field widths of the stream items.
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int LENGTH_W = 7;
    localparam int GAP_W    = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(5);

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;  // input request taken this cycle
        logic issue;   // load the next result into the output register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic last_item;   // the result about to be issued ends this read
    } t_dp_status;

endpackage

### sv/sgfr_ram.sv
module sgfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds while idle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sgfr_ctrl.sv
module sgfr_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [sgfr_pkg::CMD_W-1:0] i_command,
    input  sgfr_pkg::t_dp_status      i_status,
    output logic                      o_ready,
    output sgfr_pkg::t_dp_cmd         o_cmd
);

    import sgfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_STREAM = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Requests are taken while idle; a read request moves to streaming.
    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.issue  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && (i_command == CMD_READ)) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                o_cmd.issue = i_status.out_free;
                if (i_status.out_free && i_status.last_item) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/sgfr_datapath.sv
module sgfr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgfr_pkg::t_dp_cmd             i_cmd,
    output sgfr_pkg::t_dp_status          o_status,
    input  logic [sgfr_pkg::CMD_W-1:0]    i_command,
    input  logic [sgfr_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic [sgfr_pkg::LIMIT_W-1:0]  i_read_limit,
    input  logic                          i_cfg_we,
    input  logic [sgfr_pkg::GAP_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_frame_ready,
    output logic [sgfr_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [sgfr_pkg::INDEX_W-1:0]  o_byte_index,
    output logic [sgfr_pkg::LENGTH_W-1:0] o_read_len,
    output logic                          o_last
);

    import sgfr_pkg::*;

    logic [GAP_W-1:0]   r_gap;
    logic [GAP_W-1:0]   r_silence;
    logic [COUNT_W-1:0] r_byte_count;
    logic [COUNT_W-1:0] r_len;
    logic               r_empty;
    logic [ADDR_W-1:0]  r_rd_idx;

    logic               r_out_valid;
    logic               r_out_frame;
    logic [ADDR_W-1:0]  r_out_idx;
    logic [COUNT_W-1:0] r_out_len;
    logic               r_out_last;

    logic               take_byte;
    logic               take_tick;
    logic               take_read;
    logic               buf_room;
    logic               frame_ok;
    logic [LIMIT_W-1:0] count_ext;
    logic [LIMIT_W-1:0] emit_n;
    logic               out_free;
    logic               last_item;
    logic [BYTE_W-1:0]  ram_q;

    assign take_byte = i_cmd.accept && (i_command == CMD_BYTE);
    assign take_tick = i_cmd.accept && (i_command == CMD_TICK);
    assign take_read = i_cmd.accept && (i_command == CMD_READ);
    assign buf_room  = (r_byte_count < COUNT_W'(BUFFER_DEPTH));

    // A frame is ready once bytes are held, the read limit is nonzero and the line has been quiet long enough.
    assign count_ext = LIMIT_W'(r_byte_count);
    assign frame_ok  = (i_read_limit != '0) && (r_byte_count != '0) && (r_silence >= r_gap);
    assign emit_n    = (count_ext < i_read_limit) ? count_ext : i_read_limit;

    // Handshake toward the output register and the end of the current read.
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_item = r_empty || ((COUNT_W'(r_rd_idx) + COUNT_W'(1)) == r_len);
    assign o_status.out_free  = out_free;
    assign o_status.last_item = last_item;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            r_gap <= i_cfg_data;
        end
    end

    // Silence counter: cleared by every byte, saturating on ticks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= '0;
        end else if (take_byte) begin
            r_silence <= '0;
        end else if (take_tick && (r_silence != '1)) begin
            r_silence <= r_silence + GAP_W'(1);
        end
    end

    // Fill count of the buffer, and the read plan latched with a read request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_rd_idx     <= '0;
        end else begin
            if (take_byte && buf_room) begin
                r_byte_count <= r_byte_count + COUNT_W'(1);
            end else if (take_read && frame_ok) begin
                r_byte_count <= '0;
            end
            if (take_read) begin
                r_rd_idx <= '0;
            end else if (i_cmd.issue) begin
                r_rd_idx <= r_rd_idx + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_read) begin
            r_empty <= !frame_ok;
            r_len   <= frame_ok ? COUNT_W'(emit_n) : '0;
        end
    end

    // Output register; the byte itself comes from the buffer's read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_out_frame <= !r_empty;
            r_out_idx   <= r_rd_idx;
            r_out_len   <= r_len;
            r_out_last  <= last_item;
        end
    end

    sgfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (take_byte && buf_room),
        .i_waddr (r_byte_count[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.issue && !r_empty),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_q)
    );

    assign o_out_valid    = r_out_valid;
    assign o_frame_ready  = r_out_frame;
    assign o_data_byte    = r_out_frame ? ram_q : '0;
    assign o_byte_index   = r_out_frame ? INDEX_W'(r_out_idx) : '0;
    assign o_read_len     = LENGTH_W'(r_out_len);
    assign o_last         = r_out_frame && r_out_last;

endmodule

### sv/silence_gap_frame_receiver.sv
// Serial bytes (tuser command 0) fill a 64-entry buffer and restart a silence
// counter; millisecond ticks (command 1) advance that counter, which saturates;
// a read request (command 2) streams out the held frame, cut to read_limit,
// once the line has been quiet for gap_ticks ticks, and empties the buffer.
// A read that finds no complete frame gives a single all-zero result. Byte and
// tick requests are taken while idle and leave the block idle. A read holds
// the input until its last result is issued: its bytes leave one per cycle,
// while the output side does not stall, from the buffer RAM's read port. The
// next request is taken at the clock edge after the one that loads the last
// result into the output register. gap_ticks resets to 5. gap_ticks is to be
// written on the cfg channel only while the block is idle; the block itself
// does not enforce this.
module silence_gap_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: gap_ticks.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], read_limit[14:8], zero[15]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data_byte[7:0], byte_index[13:8],
                                        // read_len[20:14], zero[23:21]
    output logic        m_axis_tuser,   // frame_ready
    output logic        m_axis_tlast
);

    import sgfr_pkg::*;

    t_dp_cmd             dp_cmd;
    t_dp_status          dp_status;
    logic [BYTE_W-1:0]   data_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic [LENGTH_W-1:0] read_len;

    assign o_cfg_ready = 1'b1;

    sgfr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_command (s_axis_tuser),
        .i_status  (dp_status),
        .o_ready   (s_axis_tready),
        .o_cmd     (dp_cmd)
    );

    sgfr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_command      (s_axis_tuser),
        .i_rx_byte      (s_axis_tdata[7:0]),
        .i_read_limit   (s_axis_tdata[14:8]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_frame_ready  (m_axis_tuser),
        .o_data_byte    (data_byte),
        .o_byte_index   (byte_index),
        .o_read_len     (read_len),
        .o_last         (m_axis_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {3'b000, read_len, byte_index, data_byte};

endmodule
